/* hw/rtl/lje_pkg.sv */
`default_nettype none
package lje_pkg;

   // field and datapath widths
   localparam int COORD_W  = 24;
   localparam int MAG_W    = 24;               // |dx| of two Q8.16 points
   localparam int SQ_W     = 2 * MAG_W;        // dx^2
   localparam int D2_W     = SQ_W + 1;         // dx^2 + dy^2
   localparam int INV_W    = 63;               // inverse powers, units 2^-30
   localparam int TERM_W   = 57;               // pair terms, units 2^-24
   localparam int SUM_W    = TERM_W + 2;       // sum of six terms
   localparam int DIFF_W   = SUM_W + 1;
   localparam int ENERGY_W = 48;
   localparam int COEF_W   = 32;
   localparam int CARRIED  = 4;
   localparam int NUM_LANES = 6;

   // pipeline depths
   localparam int DIV_STAGES = INV_W;          // one quotient bit per stage
   localparam int MUL_LAT    = 2;
   localparam int LANE_LAT   = 3 + DIV_STAGES + 4 * MUL_LAT;
   localparam int TOTAL_LAT  = LANE_LAT + 3;   // input reg, merge, output reg

   // saturation limits
   localparam logic [INV_W-1:0] CAP_INV  = INV_W'(1) << 62;
   localparam logic [INV_W-1:0] CAP_TERM = INV_W'(1) << 56;
   localparam logic [ENERGY_W-1:0] E_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
   localparam logic [ENERGY_W-1:0] E_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};

   // register indexes
   localparam logic REG_REPULSIVE  = 1'b0;
   localparam logic REG_ATTRACTIVE = 1'b1;
   localparam logic [COEF_W-1:0] COEF_RESET = 32'h0001_0000;

   // point pairs handled by each lane
   localparam logic [1:0] PAIR_FIRST  [NUM_LANES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
   localparam logic [1:0] PAIR_SECOND [NUM_LANES] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [COEF_W-1:0]         coef_type;
   typedef logic [INV_W-1:0]          inv_type;
   typedef logic [TERM_W-1:0]         term_type;

   // overflow status of one lane
   typedef struct packed {
      logic rov;
      logic aov;
   } lane_flags_type;

endpackage
`default_nettype wire

/* hw/rtl/lje_div.sv */
`default_nettype none
// Pipelined restoring divider: quo = floor(2^62 / den), one bit per stage.
module lje_div (
   input  wire logic                       clock,
   input  wire logic [lje_pkg::D2_W-1:0]   den,
   output logic      [lje_pkg::INV_W-1:0]  quo
);
   import lje_pkg::*;

   logic [D2_W-1:0]  rem_ff [DIV_STAGES-1];
   logic [D2_W-1:0]  den_ff [DIV_STAGES-1];
   logic [INV_W-1:0] quo_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic [D2_W-1:0]  prev_rem;
      logic [D2_W-1:0]  prev_den;
      logic [INV_W-1:0] prev_quo;
      logic [D2_W:0]    trial;
      logic [D2_W:0]    diff;
      logic             ge;

      if (s == 0) begin : g_first
         assign prev_rem = '0;
         assign prev_den = den;
         assign prev_quo = '0;
         // the dividend's only set bit enters here
         assign trial    = {prev_rem, 1'b1};
      end else begin : g_next
         assign prev_rem = rem_ff[s-1];
         assign prev_den = den_ff[s-1];
         assign prev_quo = quo_ff[s-1];
         assign trial    = {prev_rem, 1'b0};
      end

      assign diff = trial - {1'b0, prev_den};
      assign ge   = (trial >= {1'b0, prev_den});

      always_ff @(posedge clock) begin
         quo_ff[s] <= {prev_quo[INV_W-2:0], ge};
      end

      if (s < DIV_STAGES - 1) begin : g_carry
         logic [D2_W-1:0] rem_in;
         assign rem_in = ge ? diff[D2_W-1:0] : trial[D2_W-1:0];
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= prev_den;
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

/* hw/rtl/lje_mul.sv */
`default_nettype none
// prod = min(floor(opa*opb / 2^SHIFT), LIMIT), from four registered partial products
module lje_mul #(
   parameter int                        SHIFT = 30,
   parameter logic [lje_pkg::INV_W-1:0] LIMIT = lje_pkg::CAP_INV
) (
   input  wire logic                       clock,
   input  wire logic [lje_pkg::INV_W-1:0]  opa,
   input  wire logic [lje_pkg::INV_W-1:0]  opb,
   output logic      [lje_pkg::INV_W-1:0]  prod,
   output logic                            ovf
);
   import lje_pkg::*;

   logic [63:0]      ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0]     full;
   logic [127:0]     shifted;
   logic             ovf_in;
   logic [INV_W-1:0] prod_in;
   logic [INV_W-1:0] prod_ff;
   logic             ovf_ff;

   // partial products
   always_ff @(posedge clock) begin
      ll_ff <= {32'd0, opa[31:0]} * {32'd0, opb[31:0]};
      lh_ff <= {32'd0, opa[31:0]} * {33'd0, opb[INV_W-1:32]};
      hl_ff <= {33'd0, opa[INV_W-1:32]} * {32'd0, opb[31:0]};
      hh_ff <= {33'd0, opa[INV_W-1:32]} * {33'd0, opb[INV_W-1:32]};
   end

   // combine, scale and clamp
   always_comb begin
      full    = {64'd0, ll_ff} + ({64'd0, lh_ff} << 32) + ({64'd0, hl_ff} << 32)
              + ({64'd0, hh_ff} << 64);
      shifted = full >> SHIFT;
      ovf_in  = (shifted > {{(128-INV_W){1'b0}}, LIMIT});
      prod_in = ovf_in ? LIMIT : shifted[INV_W-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      ovf_ff  <= ovf_in;
   end

   assign prod = prod_ff;
   assign ovf  = ovf_ff;

endmodule
`default_nettype wire

/* hw/rtl/lje_lane.sv */
`default_nettype none
// One pair energy: distance, inverse powers, both terms and overflow flags.
module lje_lane (
   input  wire logic                            clock,
   input  wire lje_pkg::coord_type              x_a,
   input  wire lje_pkg::coord_type              y_a,
   input  wire lje_pkg::coord_type              x_b,
   input  wire lje_pkg::coord_type              y_b,
   input  wire logic                            en,
   input  wire lje_pkg::coef_type               rep_coef,
   input  wire lje_pkg::coef_type               att_coef,
   output lje_pkg::term_type                    rep,
   output lje_pkg::term_type                    att,
   output lje_pkg::lane_flags_type              flags
);
   import lje_pkg::*;

   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0]        ndx, ndy;
   logic [MAG_W-1:0]        magx_in, magy_in, magx_ff, magy_ff;
   logic [SQ_W-1:0]         sqx_ff, sqy_ff;
   logic [D2_W-1:0]         d2_ff;
   inv_type                 inv2, inv4, inv6, inv12, rep_p, att_p;
   logic                    o4, o6x, o12, orp, oat;
   inv_type                 inv2_d [MUL_LAT];
   inv_type                 att_d  [MUL_LAT];
   logic                    o4_d   [MUL_LAT];
   logic                    o6_d   [2*MUL_LAT];
   logic                    o12_d  [MUL_LAT];
   logic                    oat_d  [MUL_LAT];
   logic                    zero_ff [DIV_STAGES + 4*MUL_LAT];
   logic                    en_ff   [LANE_LAT];
   logic                    o6, zero, use_it;

   // absolute differences
   always_comb begin
      dx      = {x_b[COORD_W-1], x_b} - {x_a[COORD_W-1], x_a};
      dy      = {y_b[COORD_W-1], y_b} - {y_a[COORD_W-1], y_a};
      ndx     = -dx;
      ndy     = -dy;
      magx_in = dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
      magy_in = dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
   end

   // squares, then squared distance
   always_ff @(posedge clock) begin
      magx_ff <= magx_in;
      magy_ff <= magy_in;
      sqx_ff  <= {{MAG_W{1'b0}}, magx_ff} * {{MAG_W{1'b0}}, magx_ff};
      sqy_ff  <= {{MAG_W{1'b0}}, magy_ff} * {{MAG_W{1'b0}}, magy_ff};
      d2_ff   <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
   end

   lje_div u_div (.clock(clock), .den(d2_ff), .quo(inv2));

   lje_mul #(.SHIFT(30), .LIMIT(CAP_INV)) u_inv4 (
      .clock(clock), .opa(inv2), .opb(inv2), .prod(inv4), .ovf(o4));
   lje_mul #(.SHIFT(30), .LIMIT(CAP_INV)) u_inv6 (
      .clock(clock), .opa(inv4), .opb(inv2_d[MUL_LAT-1]), .prod(inv6), .ovf(o6x));
   lje_mul #(.SHIFT(30), .LIMIT(CAP_INV)) u_inv12 (
      .clock(clock), .opa(inv6), .opb(inv6), .prod(inv12), .ovf(o12));
   lje_mul #(.SHIFT(22), .LIMIT(CAP_TERM)) u_att (
      .clock(clock), .opa({31'd0, att_coef}), .opb(inv6), .prod(att_p), .ovf(oat));
   lje_mul #(.SHIFT(22), .LIMIT(CAP_TERM)) u_rep (
      .clock(clock), .opa({31'd0, rep_coef}), .opb(inv12), .prod(rep_p), .ovf(orp));

   assign o6 = o4_d[MUL_LAT-1] | o6x;

   // alignment delays
   always_ff @(posedge clock) begin
      inv2_d[0]  <= inv2;
      att_d[0]   <= att_p;
      o4_d[0]    <= o4;
      o6_d[0]    <= o6;
      o12_d[0]   <= o12;
      oat_d[0]   <= oat;
      zero_ff[0] <= (d2_ff == '0);
      en_ff[0]   <= en;
      for (int k = 1; k < MUL_LAT; k++) begin
         inv2_d[k] <= inv2_d[k-1];
         att_d[k]  <= att_d[k-1];
         o4_d[k]   <= o4_d[k-1];
         o12_d[k]  <= o12_d[k-1];
         oat_d[k]  <= oat_d[k-1];
      end
      for (int k = 1; k < 2*MUL_LAT; k++) begin
         o6_d[k] <= o6_d[k-1];
      end
      for (int k = 1; k < DIV_STAGES + 4*MUL_LAT; k++) begin
         zero_ff[k] <= zero_ff[k-1];
      end
      for (int k = 1; k < LANE_LAT; k++) begin
         en_ff[k] <= en_ff[k-1];
      end
   end

   // gate results; a coincident pair counts as overflow of each term with a nonzero coefficient
   always_comb begin
      zero      = zero_ff[DIV_STAGES + 4*MUL_LAT - 1];
      use_it    = en_ff[LANE_LAT-1];
      rep       = (use_it && !zero) ? rep_p[TERM_W-1:0] : '0;
      att       = (use_it && !zero) ? att_d[MUL_LAT-1][TERM_W-1:0] : '0;
      flags.rov = use_it && (rep_coef != '0)
                  && (zero || o6_d[2*MUL_LAT-1] || o12_d[MUL_LAT-1] || orp);
      flags.aov = use_it && (att_coef != '0)
                  && (zero || o6_d[2*MUL_LAT-1] || oat_d[MUL_LAT-1]);
   end

endmodule
`default_nettype wire

/* hw/rtl/lennard_jones_energy_four_points.sv */
`default_nettype none
// Channel   Ports                                    Handshake
// request   req_func, req_vertex_index, req_*_point* start && !busy
// response  rsp_energy, rsp_saturated                rsp_strobe, one cycle
// config    csr_index, csr_wdata                     csr_we
//
// One request per cycle while busy is low. Each response passes the input
// register, the 63-stage quotient pipeline of 2^62/d^2 and four multiply
// stages in each of the six pair lanes, then the merge and output registers.
// busy is high only during reset (synchronous, active high).
// Responses cannot be held off by the receiver.
module lennard_jones_energy_four_points #(
   parameter int NUM_POINTS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_func,
   input  wire logic [1:0]                    req_vertex_index,
   input  wire lje_pkg::coord_type            req_x_point0,
   input  wire lje_pkg::coord_type            req_y_point0,
   input  wire lje_pkg::coord_type            req_x_point1,
   input  wire lje_pkg::coord_type            req_y_point1,
   input  wire lje_pkg::coord_type            req_x_point2,
   input  wire lje_pkg::coord_type            req_y_point2,
   input  wire lje_pkg::coord_type            req_x_point3,
   input  wire lje_pkg::coord_type            req_y_point3,
   output logic                               rsp_strobe,
   output logic signed [lje_pkg::ENERGY_W-1:0] rsp_energy,
   output logic                               rsp_saturated,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire lje_pkg::coef_type             csr_wdata
);
   import lje_pkg::*;

   localparam int N_USED = (NUM_POINTS < CARRIED) ? NUM_POINTS : CARRIED;
   localparam logic signed [DIFF_W-1:0] DIFF_MAX = {{(DIFF_W-ENERGY_W){1'b0}}, E_MAX};
   localparam logic signed [DIFF_W-1:0] DIFF_MIN = {{(DIFF_W-ENERGY_W){1'b1}}, E_MIN};

   coef_type       rep_coef_ff, att_coef_ff;
   logic           accept;
   logic           vld_ff [TOTAL_LAT];
   coord_type      px_in [CARRIED];
   coord_type      py_in [CARRIED];
   coord_type      px_ff [CARRIED];
   coord_type      py_ff [CARRIED];
   logic           en_in [NUM_LANES];
   logic           en_ff [NUM_LANES];
   term_type       lane_rep [NUM_LANES];
   term_type       lane_att [NUM_LANES];
   lane_flags_type lane_flags [NUM_LANES];
   logic [SUM_W-1:0] sum_rep_in, sum_att_in, sum_rep_ff, sum_att_ff;
   lane_flags_type   merge_in, merge_ff;
   logic signed [DIFF_W-1:0] diff;
   logic [ENERGY_W-1:0] energy_in, energy_ff;
   logic                sat_in, sat_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rep_coef_ff <= COEF_RESET;
         att_coef_ff <= COEF_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_REPULSIVE:  rep_coef_ff <= csr_wdata;
            REG_ATTRACTIVE: att_coef_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // request capture and pair selection
   always_comb begin
      px_in = '{req_x_point0, req_x_point1, req_x_point2, req_x_point3};
      py_in = '{req_y_point0, req_y_point1, req_y_point2, req_y_point3};
      for (int l = 0; l < NUM_LANES; l++) begin
         en_in[l] = (int'(PAIR_SECOND[l]) < N_USED)
                    && (!req_func || req_vertex_index == PAIR_FIRST[l]
                        || req_vertex_index == PAIR_SECOND[l]);
      end
   end

   always_ff @(posedge clock) begin
      px_ff <= px_in;
      py_ff <= py_in;
      en_ff <= en_in;
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) vld_ff[k] <= 1'b0;
      end else begin
         vld_ff[0] <= accept;
         for (int k = 1; k < TOTAL_LAT; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      lje_lane u_lane (
         .clock    (clock),
         .x_a      (px_ff[PAIR_FIRST[l]]),
         .y_a      (py_ff[PAIR_FIRST[l]]),
         .x_b      (px_ff[PAIR_SECOND[l]]),
         .y_b      (py_ff[PAIR_SECOND[l]]),
         .en       (en_ff[l]),
         .rep_coef (rep_coef_ff),
         .att_coef (att_coef_ff),
         .rep      (lane_rep[l]),
         .att      (lane_att[l]),
         .flags    (lane_flags[l])
      );
   end

   // merge: sum lane terms and collect overflow
   always_comb begin
      sum_rep_in = '0;
      sum_att_in = '0;
      merge_in   = '0;
      for (int l = 0; l < NUM_LANES; l++) begin
         sum_rep_in   = sum_rep_in + {2'b00, lane_rep[l]};
         sum_att_in   = sum_att_in + {2'b00, lane_att[l]};
         merge_in.rov = merge_in.rov | lane_flags[l].rov;
         merge_in.aov = merge_in.aov | lane_flags[l].aov;
      end
   end

   always_ff @(posedge clock) begin
      sum_rep_ff <= sum_rep_in;
      sum_att_ff <= sum_att_in;
      merge_ff   <= merge_in;
   end

   // final energy with saturation
   always_comb begin
      diff = $signed({1'b0, sum_rep_ff}) - $signed({1'b0, sum_att_ff});
      if (merge_ff.rov) begin
         energy_in = E_MAX;
         sat_in    = 1'b1;
      end else if (merge_ff.aov) begin
         energy_in = E_MIN;
         sat_in    = 1'b1;
      end else if (diff > DIFF_MAX) begin
         energy_in = E_MAX;
         sat_in    = 1'b1;
      end else if (diff < DIFF_MIN) begin
         energy_in = E_MIN;
         sat_in    = 1'b1;
      end else begin
         energy_in = diff[ENERGY_W-1:0];
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      energy_ff <= energy_in;
      sat_ff    <= sat_in;
   end

   assign rsp_strobe    = vld_ff[TOTAL_LAT-1];
   assign rsp_energy    = energy_ff;
   assign rsp_saturated = sat_ff;

   // a response always traces back to a request a fixed latency earlier
   a_resp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, TOTAL_LAT))
      else $error("response without matching request");

   // a saturated response sits at one end of the range
   a_sat_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |-> (rsp_energy == E_MAX || rsp_energy == E_MIN))
      else $error("saturated energy not at a range end");

   // repulsive overflow in the merge forces the top of the range
   a_rov_max: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[TOTAL_LAT-2] && merge_ff.rov) |=> (rsp_energy == E_MAX && rsp_saturated))
      else $error("repulsive overflow not saturated high");

endmodule
`default_nettype wire
